### rtl/msa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msa_pkg: shared definitions for the multi-stack shared array
// Sizes, status codes, controller states and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

   localparam int CAPACITY = 32;
   localparam int STACKS   = 4;

   localparam int WORD_W   = 32;
   localparam int IDX_W    = 3;
   localparam int SIZE_W   = 6;
   localparam int STATUS_W = 2;

   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int PTR_W    = $clog2(CAPACITY + 1);
   localparam int CUR_W    = $clog2(STACKS + 1);
   localparam int KCMP_W   = (CUR_W > IDX_W) ? CUR_W : IDX_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_INDEX,
      STATUS_EMPTY,
      STATUS_NO_ROOM
   } status_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_TOP,
      CUR_ONE,
      CUR_DEC,
      CUR_INC,
      CUR_K
   } cur_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POP_DATA,
      ST_UP_CHK,
      ST_SLIDE_UP,
      ST_DN_CHK,
      ST_SLIDE_DN,
      ST_PUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load_req;
      cur_op_type cur_op;
      logic       slide_start;
      logic       slide_up;
      logic       bump_up;
      logic       bump_down;
      logic       pop_start;
      logic       pop_take;
      logic       push_write;
      logic       set_status;
      status_type status;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_index;
      logic is_pop;
      logic cur_full;
      logic cur_empty;
      logic cur_dn_ok;
      logic cur_eq_k;
      logic cur_gt_k;
      logic push_ok;
      logic busy;
   } dp_sts_type;

endpackage
`default_nettype wire

### rtl/msa_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msa_dpath: stack pointers, word store and slide engine
// Holds base and next-free pointers of every stack, the shared word store,
// a one-word-per-cycle slide engine and the result register.
// ----------------------------------------------------------------------------
module msa_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire msa_pkg::dp_cmd_type          cmd,
   output msa_pkg::dp_sts_type               sts,
   input  wire logic                         req_command,
   input  wire logic [msa_pkg::IDX_W-1:0]    req_index,
   input  wire logic [msa_pkg::WORD_W-1:0]   req_value,
   output logic [msa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [msa_pkg::WORD_W-1:0]        rsp_popped_value,
   output logic [msa_pkg::SIZE_W-1:0]        rsp_stack_size,
   output logic                              rsp_stack_empty,
   output logic                              rsp_stack_full
);

   localparam int PTR_W  = msa_pkg::PTR_W;
   localparam int ADDR_W = msa_pkg::ADDR_W;
   localparam int CUR_W  = msa_pkg::CUR_W;
   localparam int KCMP_W = msa_pkg::KCMP_W;
   localparam int NSTK   = msa_pkg::STACKS;

   // request latch
   logic                         command_ff, command_in;
   logic [msa_pkg::IDX_W-1:0]    k_ff, k_in;
   logic [msa_pkg::WORD_W-1:0]   word_ff, word_in;
   logic [CUR_W-1:0]             cur_ff, cur_in;

   // pointers
   logic [PTR_W-1:0] base_ff [NSTK];
   logic [PTR_W-1:0] base_in [NSTK];
   logic [PTR_W-1:0] nf_ff   [NSTK];
   logic [PTR_W-1:0] nf_in   [NSTK];
   logic [PTR_W-1:0] lim     [NSTK];
   logic [NSTK-1:0]  full_v, empty_v, dn_ok_v;

   logic [PTR_W-1:0] base_cur, nf_cur;
   logic             full_cur, empty_cur, dn_ok_cur;

   // slide engine
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [PTR_W-1:0]  cnt_ff, cnt_in;
   logic              up_ff, up_in;
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;

   // store
   logic [msa_pkg::WORD_W-1:0] entry_mem [msa_pkg::CAPACITY];
   logic [msa_pkg::WORD_W-1:0] rd_data_ff;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
   logic [msa_pkg::WORD_W-1:0] mem_wdata;

   // results
   logic [msa_pkg::WORD_W-1:0]   popped_ff, popped_in;
   msa_pkg::status_type          status_ff, status_in;
   logic [msa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [msa_pkg::WORD_W-1:0]   rsp_popped_ff, rsp_popped_in;
   logic [msa_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic                         rsp_full_ff, rsp_full_in;

   // per-stack flags, each at a fixed place
   always_comb begin
      for (int s = 0; s < NSTK; s++) begin
         lim[s] = PTR_W'(msa_pkg::CAPACITY);
      end
      for (int s = 0; s < NSTK - 1; s++) begin
         lim[s] = base_ff[s + 1];
      end
      for (int s = 0; s < NSTK; s++) begin
         full_v[s]  = (nf_ff[s] >= lim[s]);
         empty_v[s] = (nf_ff[s] <= base_ff[s]);
      end
      dn_ok_v[0] = 1'b0;
      for (int s = 1; s < NSTK; s++) begin
         dn_ok_v[s] = !full_v[s - 1] && (base_ff[s] != '0);
      end
   end

   // select the stack under the cursor
   always_comb begin
      base_cur  = '0;
      nf_cur    = '0;
      full_cur  = 1'b0;
      empty_cur = 1'b0;
      dn_ok_cur = 1'b0;
      for (int s = 0; s < NSTK; s++) begin
         if (cur_ff == CUR_W'(s)) begin
            base_cur  = base_ff[s];
            nf_cur    = nf_ff[s];
            full_cur  = full_v[s];
            empty_cur = empty_v[s];
            dn_ok_cur = dn_ok_v[s];
         end
      end
   end

   // request latch and cursor
   always_comb begin
      command_in = command_ff;
      k_in       = k_ff;
      word_in    = word_ff;
      cur_in     = cur_ff;
      case (cmd.cur_op)
         msa_pkg::CUR_HOLD: cur_in = cur_ff;
         msa_pkg::CUR_TOP:  cur_in = CUR_W'(NSTK - 1);
         msa_pkg::CUR_ONE:  cur_in = CUR_W'(1);
         msa_pkg::CUR_DEC:  cur_in = cur_ff - CUR_W'(1);
         msa_pkg::CUR_INC:  cur_in = cur_ff + CUR_W'(1);
         msa_pkg::CUR_K:    cur_in = CUR_W'(k_ff);
         default:           cur_in = cur_ff;
      endcase
      if (cmd.load_req) begin
         command_in = req_command;
         k_in       = req_index;
         word_in    = req_value;
         cur_in     = CUR_W'(req_index);
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      k_ff       <= k_in;
      word_ff    <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   // pointer updates on the stack under the cursor
   always_comb begin
      base_in = base_ff;
      nf_in   = nf_ff;
      for (int s = 0; s < NSTK; s++) begin
         if (cur_ff == CUR_W'(s)) begin
            if (cmd.bump_up) begin
               base_in[s] = base_ff[s] + PTR_W'(1);
               nf_in[s]   = nf_ff[s] + PTR_W'(1);
            end
            if (cmd.bump_down) begin
               base_in[s] = base_ff[s] - PTR_W'(1);
               nf_in[s]   = nf_ff[s] - PTR_W'(1);
            end
            if (cmd.pop_start) begin
               nf_in[s] = nf_ff[s] - PTR_W'(1);
            end
            if (cmd.push_write) begin
               nf_in[s] = nf_ff[s] + PTR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTK; s++) begin
            base_ff[s] <= PTR_W'((s * msa_pkg::CAPACITY) / msa_pkg::STACKS);
            nf_ff[s]   <= PTR_W'((s * msa_pkg::CAPACITY) / msa_pkg::STACKS);
         end
      end else begin
         base_ff <= base_in;
         nf_ff   <= nf_in;
      end
   end

   // slide engine: read one word ahead, write it in the next cycle
   always_comb begin
      src_in   = src_ff;
      cnt_in   = cnt_ff;
      up_in    = up_ff;
      wpend_in = 1'b0;
      waddr_in = waddr_ff;
      if (cnt_ff != '0) begin
         wpend_in = 1'b1;
         waddr_in = up_ff ? (src_ff + ADDR_W'(1)) : (src_ff - ADDR_W'(1));
         src_in   = up_ff ? (src_ff - ADDR_W'(1)) : (src_ff + ADDR_W'(1));
         cnt_in   = cnt_ff - PTR_W'(1);
      end
      if (cmd.slide_start) begin
         cnt_in = nf_cur - base_cur;
         up_in  = cmd.slide_up;
         src_in = cmd.slide_up ? ADDR_W'(nf_cur - PTR_W'(1)) : ADDR_W'(base_cur);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         wpend_ff <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      up_ff    <= up_in;
      waddr_ff <= waddr_in;
   end

   // store ports
   always_comb begin
      mem_we    = wpend_ff || cmd.push_write;
      mem_waddr = wpend_ff ? waddr_ff : ADDR_W'(nf_cur);
      mem_wdata = wpend_ff ? rd_data_ff : word_ff;
      mem_raddr = (cnt_ff != '0) ? src_ff : ADDR_W'(nf_cur - PTR_W'(1));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   // status, popped word and result register
   always_comb begin
      popped_in = popped_ff;
      status_in = status_ff;
      if (cmd.load_req) begin
         popped_in = '0;
         status_in = msa_pkg::STATUS_OK;
      end
      if (cmd.pop_take) begin
         popped_in = rd_data_ff;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end

      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (cmd.rsp_load) begin
         rsp_status_in = status_ff;
         rsp_popped_in = popped_ff;
         if (status_ff == msa_pkg::STATUS_BAD_INDEX) begin
            rsp_size_in  = '0;
            rsp_empty_in = 1'b0;
            rsp_full_in  = 1'b1;
         end else begin
            rsp_size_in  = msa_pkg::SIZE_W'(nf_cur - base_cur);
            rsp_empty_in = empty_cur;
            rsp_full_in  = full_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   always_comb begin
      sts.bad_index = (KCMP_W'(k_ff) >= KCMP_W'(NSTK));
      sts.is_pop    = command_ff;
      sts.cur_full  = full_cur;
      sts.cur_empty = empty_cur;
      sts.cur_dn_ok = dn_ok_cur;
      sts.cur_eq_k  = (KCMP_W'(cur_ff) == KCMP_W'(k_ff));
      sts.cur_gt_k  = (KCMP_W'(cur_ff) > KCMP_W'(k_ff));
      sts.push_ok   = !full_cur && (nf_cur < PTR_W'(msa_pkg::CAPACITY));
      sts.busy      = (cnt_ff != '0) || wpend_ff;
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_stack_size   = rsp_size_ff;
   assign rsp_stack_empty  = rsp_empty_ff;
   assign rsp_stack_full   = rsp_full_ff;

endmodule
`default_nettype wire

### rtl/msa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msa_ctrl: command sequencer
// Steps one item through index check, upward slides, downward slides and
// the push or pop itself, then hands the result to the output register.
// ----------------------------------------------------------------------------
module msa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output msa_pkg::dp_cmd_type       cmd,
   input  wire msa_pkg::dp_sts_type  sts
);

   msa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.cur_op = msa_pkg::CUR_HOLD;
      cmd.status = msa_pkg::STATUS_OK;
      req_tready = 1'b0;

      case (state_ff)
         msa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = msa_pkg::ST_CHECK;
            end
         end
         msa_pkg::ST_CHECK: begin
            if (sts.bad_index) begin
               cmd.set_status = 1'b1;
               cmd.status     = msa_pkg::STATUS_BAD_INDEX;
               state_in       = msa_pkg::ST_FINISH;
            end else if (sts.is_pop) begin
               if (sts.cur_empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = msa_pkg::STATUS_EMPTY;
                  state_in       = msa_pkg::ST_FINISH;
               end else begin
                  cmd.pop_start = 1'b1;
                  state_in      = msa_pkg::ST_POP_DATA;
               end
            end else if (!sts.cur_full) begin
               state_in = msa_pkg::ST_PUSH;
            end else begin
               cmd.cur_op = msa_pkg::CUR_TOP;
               state_in   = msa_pkg::ST_UP_CHK;
            end
         end
         msa_pkg::ST_POP_DATA: begin
            cmd.pop_take   = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = msa_pkg::STATUS_OK;
            state_in       = msa_pkg::ST_FINISH;
         end
         msa_pkg::ST_UP_CHK: begin
            if (sts.cur_eq_k) begin
               if (sts.cur_full) begin
                  cmd.cur_op = msa_pkg::CUR_ONE;
                  state_in   = msa_pkg::ST_DN_CHK;
               end else begin
                  state_in = msa_pkg::ST_PUSH;
               end
            end else if (sts.cur_full) begin
               cmd.cur_op = msa_pkg::CUR_DEC;
            end else begin
               cmd.slide_start = 1'b1;
               cmd.slide_up    = 1'b1;
               state_in        = msa_pkg::ST_SLIDE_UP;
            end
         end
         msa_pkg::ST_SLIDE_UP: begin
            if (!sts.busy) begin
               cmd.bump_up = 1'b1;
               cmd.cur_op  = msa_pkg::CUR_DEC;
               state_in    = msa_pkg::ST_UP_CHK;
            end
         end
         msa_pkg::ST_DN_CHK: begin
            if (sts.cur_gt_k) begin
               cmd.cur_op = msa_pkg::CUR_K;
               state_in   = msa_pkg::ST_PUSH;
            end else if (sts.cur_dn_ok) begin
               cmd.slide_start = 1'b1;
               cmd.slide_up    = 1'b0;
               state_in        = msa_pkg::ST_SLIDE_DN;
            end else begin
               cmd.cur_op = msa_pkg::CUR_INC;
            end
         end
         msa_pkg::ST_SLIDE_DN: begin
            if (!sts.busy) begin
               cmd.bump_down = 1'b1;
               cmd.cur_op    = msa_pkg::CUR_INC;
               state_in      = msa_pkg::ST_DN_CHK;
            end
         end
         msa_pkg::ST_PUSH: begin
            cmd.set_status = 1'b1;
            if (sts.push_ok) begin
               cmd.push_write = 1'b1;
               cmd.status     = msa_pkg::STATUS_OK;
            end else begin
               cmd.status = msa_pkg::STATUS_NO_ROOM;
            end
            state_in = msa_pkg::ST_FINISH;
         end
         msa_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = msa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msa_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in flight");

   a_check_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msa_pkg::ST_CHECK) |-> $past(req_tvalid && req_tready))
      else $error("check step without an accepted item");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(state_ff == msa_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_slide_done_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msa_pkg::ST_SLIDE_UP && !sts.busy) |=> (state_ff == msa_pkg::ST_UP_CHK))
      else $error("upward slide did not return to its check step");
`endif

endmodule
`default_nettype wire

### rtl/multi_stack_shared_array.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_shared_array: several stacks in one shared word store
// Use: send push or pop items on req_*, take one result per item on rsp_*.
//   req_tuser selects push (0) or pop (1); req_tdata carries stack index and
//   push word. rsp_tuser carries the status code; rsp_tdata carries popped
//   word, size, empty and full of the addressed stack after the item.
// Items are handled one at a time: req_tready is high only while idle.
//   A push to a full stack walks the other stacks one check per cycle and
//   slides each movable stack through the word store one word per cycle.
// A new item is accepted once the previous one is in the output register,
//   even while that result still waits for rsp_tready; a stalled result
//   holds its value and the next result waits behind it.
// Reset (synchronous, active high) gives every stack an equal empty share
//   and clears the handshake; the word store itself is not cleared.
// ----------------------------------------------------------------------------
module multi_stack_shared_array (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [2:0] stack_index, [34:3] push_value, rest 0
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] popped_value, [37:32] stack_size,
                                         // [38] stack_empty, [39] stack_full
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   msa_pkg::dp_cmd_type cmd;
   msa_pkg::dp_sts_type sts;

   logic [msa_pkg::WORD_W-1:0] popped_value;
   logic [msa_pkg::SIZE_W-1:0] stack_size;
   logic                       stack_empty;
   logic                       stack_full;

   msa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   msa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_tuser),
      .req_index        (req_tdata[2:0]),
      .req_value        (req_tdata[34:3]),
      .rsp_status       (rsp_tuser),
      .rsp_popped_value (popped_value),
      .rsp_stack_size   (stack_size),
      .rsp_stack_empty  (stack_empty),
      .rsp_stack_full   (stack_full)
   );

   assign rsp_tdata = {stack_full, stack_empty, stack_size, popped_value};

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for multi_stack_shared_array
// Drives push and pop items on the request stream and predicts each result
// from an internal model of the shared store and the stack pointers.
// Covers bad indexes, pops from empty stacks, growth of the lowest, a middle
// and the highest stack over its neighbors, a full store, and random traffic under
// random gaps, stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY     = msa_pkg::CAPACITY;
   localparam int STACKS       = msa_pkg::STACKS;
   localparam int WORD_W       = msa_pkg::WORD_W;
   localparam int IDX_W        = msa_pkg::IDX_W;
   localparam int SIZE_W       = msa_pkg::SIZE_W;
   localparam int MAX_INDEX    = (1 << IDX_W) - 1;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = CAPACITY + 3 * STACKS + 16;
   localparam int LIMIT_CYCLES = 1_000_000;

   typedef enum bit {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef struct {
      msa_pkg::status_type status;
      logic [WORD_W-1:0]   popped;
      logic [SIZE_W-1:0]   size;
      logic                empty;
      logic                full;
   } stack_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // model of the block
   logic [WORD_W-1:0] words [CAPACITY];
   int                base_of [STACKS];
   int                top_of [STACKS];

   stack_result_type pending_results [$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   bit               sender_gaps = 1'b0;
   bit               receiver_stalls = 1'b0;
   bit               hold_request = 1'b0;
   int unsigned      stall_left = 0;

   multi_stack_shared_array dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void reset_stacks();
      for (int i = 0; i < CAPACITY; i++) words[i] = '0;
      for (int i = 0; i < STACKS; i++) begin
         base_of[i] = (i * CAPACITY) / STACKS;
         top_of[i]  = base_of[i];
      end
   endfunction

   function automatic int limit_of(int s);
      return (s + 1 < STACKS) ? base_of[s + 1] : CAPACITY;
   endfunction

   function automatic bit full_at(int s);
      return top_of[s] >= limit_of(s);
   endfunction

   function automatic bit empty_at(int s);
      return top_of[s] <= base_of[s];
   endfunction

   function automatic void shift_right(int s);
      if (full_at(s)) return;
      for (int j = top_of[s]; j > base_of[s]; j--) begin
         if (j < CAPACITY) words[j] = words[j - 1];
      end
      base_of[s]++;
      top_of[s]++;
   endfunction

   function automatic void shift_left(int s);
      if (s < 1 || s >= STACKS) return;
      if (full_at(s - 1) || base_of[s] == 0) return;
      for (int j = base_of[s]; j < top_of[s]; j++) begin
         if (j < CAPACITY) words[j - 1] = words[j];
      end
      base_of[s]--;
      top_of[s]--;
   endfunction

   function automatic stack_result_type apply_command(command_type cmd, int k,
                                                      logic [WORD_W-1:0] value);
      stack_result_type r;
      r.status = msa_pkg::STATUS_OK;
      r.popped = '0;
      r.size   = '0;
      r.empty  = 1'b0;
      r.full   = 1'b1;
      if (k >= STACKS) begin
         r.status = msa_pkg::STATUS_BAD_INDEX;
         return r;
      end
      if (cmd == CMD_POP) begin
         if (empty_at(k)) begin
            r.status = msa_pkg::STATUS_EMPTY;
         end else begin
            top_of[k]--;
            if (top_of[k] < CAPACITY) r.popped = words[top_of[k]];
         end
      end else begin
         if (full_at(k)) begin
            // make room from above first, highest stack first
            for (int i = STACKS - 1; i > k; i--) shift_right(i);
            if (full_at(k)) begin
               for (int i = 1; i <= k; i++) shift_left(i);
            end
         end
         if (full_at(k) || top_of[k] >= CAPACITY) begin
            r.status = msa_pkg::STATUS_NO_ROOM;
         end else begin
            words[top_of[k]] = value;
            top_of[k]++;
         end
      end
      r.size  = SIZE_W'(top_of[k] - base_of[k]);
      r.empty = empty_at(k);
      r.full  = full_at(k);
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // predict on every accepted request item
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_results.push_back(apply_command(command_type'(req_tuser),
                                                 int'(req_tdata[IDX_W-1:0]),
                                                 req_tdata[IDX_W +: WORD_W]));
      end
   end

   task automatic check_field(string field, logic [WORD_W-1:0] expected_value,
                              logic [WORD_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s expected %0h actual %0h", $time, field,
                  expected_value, actual_value);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result item, tuser %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_tuser));
            check_field("popped_value", want.popped, rsp_tdata[31:0]);
            check_field("stack_size", WORD_W'(want.size), WORD_W'(rsp_tdata[37:32]));
            check_field("stack_empty", WORD_W'(want.empty), WORD_W'(rsp_tdata[38]));
            check_field("stack_full", WORD_W'(want.full), WORD_W'(rsp_tdata[39]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("multi_stack_shared_array: mismatch");
         $finish;
      end
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (receiver_stalls) stall_left = pick_gap();
         end
      end
   end

   task automatic send_item(command_type cmd, int idx, logic [WORD_W-1:0] value);
      int unsigned gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {5'b0, value, idx[IDX_W-1:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic clear_all_stacks();
      int sizes [STACKS];
      drain();
      for (int s = 0; s < STACKS; s++) sizes[s] = top_of[s] - base_of[s];
      for (int s = 0; s < STACKS; s++) begin
         repeat (sizes[s]) send_item(CMD_POP, s, pick_word());
      end
      drain();
   endtask

   task automatic test_directed();
      logic [WORD_W-1:0] extremes [4];
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_item(CMD_POP, 0, '0);
      send_item(CMD_PUSH, STACKS, 32'h1234_5678);
      send_item(CMD_POP, MAX_INDEX, '0);
      send_item(CMD_PUSH, MAX_INDEX, 32'hFFFF_FFFF);
      send_item(CMD_POP, STACKS + 1, '0);
      foreach (extremes[i]) send_item(CMD_PUSH, 0, extremes[i]);
      repeat (4) send_item(CMD_POP, 0, '0);
      send_item(CMD_PUSH, STACKS - 1, 32'hAAAA_AAAA);
      send_item(CMD_PUSH, STACKS - 1, 32'h5555_5555);
      repeat (3) send_item(CMD_POP, STACKS - 1, '0);
      send_item(CMD_PUSH, 1, 32'h0F0F_0F0F);
      send_item(CMD_PUSH, 2, 32'hF0F0_F0F0);
      send_item(CMD_POP, 2, '0);
      send_item(CMD_POP, 1, '0);
      drain();
   endtask

   // grow one stack over all the others until the store runs out
   task automatic test_fill_stack(int k);
      clear_all_stacks();
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      repeat (CAPACITY + 2) send_item(CMD_PUSH, k, pick_word());
      send_item(CMD_PUSH, (k + 1) % STACKS, pick_word());
      send_item(CMD_POP, (k + 1) % STACKS, '0);
      clear_all_stacks();
   endtask

   task automatic test_backpressure();
      drain();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_request    = 1'b1;
      repeat (24) begin
         send_item(command_type'($urandom_range(0, 1)), $urandom_range(0, STACKS - 1),
                   pick_word());
      end
      drain();
   endtask

   task automatic test_random();
      int push_pct;
      int hot;
      int idx;
      command_type cmd;
      for (int epoch = 0; epoch < 31; epoch++) begin
         case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 80;
            default: push_pct = 95;
         endcase
         sender_gaps     = ($urandom_range(0, 2) != 0);
         receiver_stalls = ($urandom_range(0, 2) != 0);
         hot = ($urandom_range(0, 1) != 0) ? $urandom_range(0, STACKS - 1) : -1;
         repeat (50) begin
            if ($urandom_range(0, 99) < 4) idx = $urandom_range(STACKS, MAX_INDEX);
            else if (hot >= 0 && $urandom_range(0, 1) != 0) idx = hot;
            else idx = $urandom_range(0, STACKS - 1);
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            send_item(cmd, idx, pick_word());
         end
         if (epoch % 8 == 7) drain();
      end
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      reset_stacks();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_fill_stack(0);
      test_fill_stack(STACKS - 1);
      test_fill_stack(1);
      test_backpressure();
      test_random();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d result items never arrived", $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("multi_stack_shared_array: match");
      end else begin
         $display("multi_stack_shared_array: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
